FILE: sv/ibd_pkg.sv
// shared types, constants and color helpers for the indicator blink and dim controller
package ibd_pkg;

  localparam int unsigned PixelW  = 4;
  localparam int unsigned StampW  = 32;
  localparam int unsigned LevelW  = 3;
  localparam int unsigned DimW    = 8;
  localparam int unsigned RgbW    = 24;
  localparam int unsigned IntW    = 16;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = 1;

  localparam logic [PixelW-1:0] LinkA = 4'd4;
  localparam logic [PixelW-1:0] LinkB = 4'd5;

  localparam logic [LevelW-1:0] LvlOff    = 3'd0;
  localparam logic [LevelW-1:0] LvlGreen  = 3'd1;
  localparam logic [LevelW-1:0] LvlOrange = 3'd2;
  localparam logic [LevelW-1:0] LvlRed    = 3'd3;
  localparam logic [LevelW-1:0] LvlBlue   = 3'd4;

  localparam logic [DimW-1:0]  FullDim       = 8'hFF;
  localparam logic [RgbW-1:0]  RgbBlack      = 24'h000000;
  localparam logic [RgbW-1:0]  RgbWhite      = 24'hFFFFFF;
  localparam logic [RgbW-1:0]  RgbGreen      = 24'h00FF00;
  localparam logic [RgbW-1:0]  RgbOrange     = {8'd255, 8'd165, 8'd0};
  localparam logic [RgbW-1:0]  RgbRed        = 24'hFF0000;
  localparam logic [RgbW-1:0]  RgbBlue       = 24'h0000FF;
  localparam logic [IntW-1:0]  IntervalReset = 16'd500;

  // codes match the func field of a beat
  typedef enum logic [1:0] {
    OpSet     = 2'd0,
    OpWork    = 2'd1,
    OpRefresh = 2'd2,
    OpClear   = 2'd3
  } ibd_op_e;

  typedef enum logic {
    StIdle,
    StWalk
  } ibd_state_e;

  typedef struct packed {
    ibd_op_e             op;
    logic [PixelW-1:0]   idx;
    logic                link;
    logic [StampW-1:0]   now;
    logic [LevelW-1:0]   level;
    logic                flash;
    logic [DimW-1:0]     dim;
    logic                enable;
    logic [RgbW-1:0]     rgb;
  } ibd_cmd_t;

  typedef struct packed {
    logic push;
    logic full;
  } ibd_qctl_t;

  function automatic logic [RgbW-1:0] ibd_level_color(input logic [LevelW-1:0] lvl);
    logic [RgbW-1:0] c;
    case (lvl)
      LvlGreen:  c = RgbGreen;
      LvlOrange: c = RgbOrange;
      LvlRed:    c = RgbRed;
      LvlBlue:   c = RgbBlue;
      default:   c = RgbBlack;
    endcase
    return c;
  endfunction

  // ch*dim/255 truncated; exact for any product of two 8-bit values
  function automatic logic [ChanW-1:0] ibd_dim_chan(input logic [ChanW-1:0] ch,
                                                   input logic [DimW-1:0]  dim);
    logic [15:0] p;
    logic [16:0] s;
    p = 16'(ch) * 16'(dim);
    s = 17'(p) + 17'(p[15:8]) + 17'd1;
    return (dim == FullDim) ? ch : s[15:8];
  endfunction

endpackage

FILE: sv/ibd_cmd_if.sv
// command channel: one beat per command
interface ibd_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] now_ms;
  logic [3:0]  index;
  logic [2:0]  level;
  logic        flash;
  logic [7:0]  brightness;
  logic        enable;
  logic [23:0] color_rgb;

  modport source (output valid, func, now_ms, index, level, flash, brightness, enable,
                  color_rgb, input ready);
  modport sink   (input valid, func, now_ms, index, level, flash, brightness, enable,
                  color_rgb, output ready);
endinterface

FILE: sv/ibd_pix_if.sv
// pixel result channel: one beat per emitted color
interface ibd_pix_if;
  logic       valid;
  logic       ready;
  logic [3:0] pixel;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last;

  modport source (output valid, pixel, red, green, blue, last, input ready);
  modport sink   (input valid, pixel, red, green, blue, last, output ready);
endinterface

FILE: sv/ibd_front.sv
// front end: takes command beats, drops sets outside the table, marks the linked pair
module ibd_front #(
  parameter int unsigned INDICATOR_COUNT = 10
) (
  ibd_cmd_if.sink            cmd_i,
  input  logic               full_i,
  output logic               push_o,
  output ibd_pkg::ibd_cmd_t  entry_o
);
  import ibd_pkg::*;

  ibd_op_e op;
  logic    keep;

  assign op          = ibd_op_e'(cmd_i.func);
  assign cmd_i.ready = !full_i;
  assign keep        = (op != OpSet) || (cmd_i.index < PixelW'(INDICATOR_COUNT));
  assign push_o      = cmd_i.valid && cmd_i.ready && keep;

  always_comb begin
    entry_o        = '0;
    entry_o.op     = op;
    entry_o.idx    = cmd_i.index;
    entry_o.link   = (cmd_i.index == LinkA) || (cmd_i.index == LinkB);
    entry_o.now    = cmd_i.now_ms;
    entry_o.level  = cmd_i.level;
    entry_o.flash  = cmd_i.flash;
    entry_o.dim    = cmd_i.brightness;
    entry_o.enable = cmd_i.enable;
    entry_o.rgb    = cmd_i.color_rgb;
  end
endmodule

FILE: sv/ibd_queue.sv
// two-entry command queue between front and back
module ibd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ibd_pkg::ibd_cmd_t  wdata_i,
  input  logic               pop_i,
  output ibd_pkg::ibd_qctl_t ctl_o,
  output logic               valid_o,
  output ibd_pkg::ibd_cmd_t  rdata_o
);
  import ibd_pkg::*;

  ibd_cmd_t         mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0]   cnt_q;
  logic             do_push, do_pop;

  assign valid_o     = (cnt_q != '0);
  assign ctl_o.full  = (cnt_q == (QPtrW+1)'(QDepth));
  assign ctl_o.push  = do_push;
  assign do_push     = push_i && !ctl_o.full;
  assign do_pop      = pop_i && valid_o;
  assign rdata_o     = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end
endmodule

FILE: sv/ibd_back.sv
// back end: indicator table, command execution and the refresh walk with dimming
module ibd_back #(
  parameter int unsigned INDICATOR_COUNT = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ibd_pkg::IntW-1:0]  cfg_wdata_i,
  input  logic                      q_valid_i,
  input  ibd_pkg::ibd_cmd_t         q_cmd_i,
  output logic                      q_pop_o,
  ibd_pix_if.source                 pix_o
);
  import ibd_pkg::*;

  localparam int unsigned IdxW = $clog2(INDICATOR_COUNT);
  localparam logic [PixelW-1:0] WorkPixel = PixelW'(INDICATOR_COUNT);

  // indicator table
  logic [LevelW-1:0] lvl_q   [INDICATOR_COUNT];
  logic              fon_q   [INDICATOR_COUNT];
  logic [StampW-1:0] stamp_q [INDICATOR_COUNT];
  logic              phase_q [INDICATOR_COUNT];
  logic [DimW-1:0]   dim_q   [INDICATOR_COUNT];

  logic              work_on_q, work_fon_q, work_phase_q;
  logic [DimW-1:0]   work_dim_q;
  logic [RgbW-1:0]   work_rgb_q;
  logic [StampW-1:0] work_stamp_q;
  logic [IntW-1:0]   interval_q;

  ibd_state_e        state_q, state_d;
  logic [PixelW-1:0] cnt_q;
  logic [StampW-1:0] now_q;

  // compute stage and output register
  logic              s1_vld_q;
  logic [PixelW-1:0] s1_pix_q;
  logic [RgbW-1:0]   s1_rgb_q;
  logic [DimW-1:0]   s1_dim_q;
  logic              s1_last_q;
  logic              out_vld_q;
  logic [PixelW-1:0] out_pix_q;
  logic [ChanW-1:0]  out_r_q, out_g_q, out_b_q;
  logic              out_last_q;

  logic                  advance, s1_load, issue, pop;
  logic                  is_work;
  logic [IdxW-1:0]       ci;
  logic [INDICATOR_COUNT-1:0] hit;
  logic [LevelW-1:0]     e_lvl;
  logic                  active, cur_phase, tog, new_phase;
  logic [StampW-1:0]     cur_stamp, elapsed;
  logic [RgbW-1:0]       base_rgb, sel_rgb;
  logic [DimW-1:0]       sel_dim;

  assign advance = !out_vld_q || pix_o.ready;
  assign s1_load = !s1_vld_q || advance;
  assign is_work = (cnt_q == WorkPixel);
  assign ci      = is_work ? '0 : cnt_q[IdxW-1:0];
  assign e_lvl   = lvl_q[ci];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (q_valid_i && q_cmd_i.op == OpRefresh) begin
          state_d = StWalk;
        end
      end
      StWalk: begin
        if (s1_load && is_work) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // fsm outputs
  always_comb begin
    pop   = 1'b0;
    issue = 1'b0;
    case (state_q)
      StIdle:  pop   = q_valid_i;
      StWalk:  issue = s1_load;
      default: ;
    endcase
  end

  assign q_pop_o = pop;

  always_comb begin
    for (int e = 0; e < INDICATOR_COUNT; e++) begin
      hit[e] = q_cmd_i.link ? (PixelW'(e) == LinkA || PixelW'(e) == LinkB)
                            : (q_cmd_i.idx == PixelW'(e));
    end
  end

  // one shared phase check for the entry or the worklight
  always_comb begin
    if (is_work) begin
      active    = work_on_q && work_fon_q;
      cur_stamp = work_stamp_q;
      cur_phase = work_phase_q;
      base_rgb  = work_on_q ? work_rgb_q : RgbBlack;
      sel_dim   = work_on_q ? work_dim_q : FullDim;
    end else begin
      active    = fon_q[ci] && (e_lvl != LvlOff) && (e_lvl <= LvlBlue);
      cur_stamp = stamp_q[ci];
      cur_phase = phase_q[ci];
      base_rgb  = ibd_level_color(e_lvl);
      sel_dim   = dim_q[ci];
    end
    elapsed   = now_q - cur_stamp;
    tog       = active && (elapsed > StampW'(interval_q));
    new_phase = cur_phase ^ tog;
    sel_rgb   = (active && !new_phase) ? RgbBlack : base_rgb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cnt_q    <= '0;
      now_q    <= '0;
      s1_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop && q_cmd_i.op == OpRefresh) begin
        cnt_q <= '0;
        now_q <= q_cmd_i.now;
      end else if (issue && !is_work) begin
        // counter parks on the worklight slot so the table index stays in range
        cnt_q <= cnt_q + 1'b1;
      end
      if (s1_load) begin
        s1_vld_q <= issue;
      end
      if (advance) begin
        out_vld_q <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_pix_q  <= cnt_q;
      s1_rgb_q  <= sel_rgb;
      s1_dim_q  <= sel_dim;
      s1_last_q <= is_work;
    end
    if (advance && s1_vld_q) begin
      out_pix_q  <= s1_pix_q;
      out_r_q    <= ibd_dim_chan(s1_rgb_q[23:16], s1_dim_q);
      out_g_q    <= ibd_dim_chan(s1_rgb_q[15:8], s1_dim_q);
      out_b_q    <= ibd_dim_chan(s1_rgb_q[7:0], s1_dim_q);
      out_last_q <= s1_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= IntervalReset;
      for (int e = 0; e < INDICATOR_COUNT; e++) begin
        lvl_q[e]   <= LvlOff;
        fon_q[e]   <= 1'b0;
        stamp_q[e] <= '0;
        phase_q[e] <= 1'b0;
        dim_q[e]   <= FullDim;
      end
      work_on_q    <= 1'b0;
      work_fon_q   <= 1'b0;
      work_phase_q <= 1'b0;
      work_dim_q   <= FullDim;
      work_rgb_q   <= RgbWhite;
      work_stamp_q <= '0;
    end else begin
      if (cfg_we_i) begin
        interval_q <= cfg_wdata_i;
      end
      if (pop) begin
        case (q_cmd_i.op)
          OpSet: begin
            for (int e = 0; e < INDICATOR_COUNT; e++) begin
              if (hit[e]) begin
                lvl_q[e] <= q_cmd_i.level;
                fon_q[e] <= q_cmd_i.flash;
                dim_q[e] <= q_cmd_i.dim;
                if (q_cmd_i.flash) begin
                  stamp_q[e] <= q_cmd_i.now;
                  phase_q[e] <= 1'b1;
                end
              end
            end
          end
          OpWork: begin
            work_on_q  <= q_cmd_i.enable;
            work_dim_q <= q_cmd_i.dim;
            work_fon_q <= q_cmd_i.flash;
            if (q_cmd_i.rgb != RgbBlack) begin
              work_rgb_q <= q_cmd_i.rgb;
            end
            if (q_cmd_i.flash) begin
              work_stamp_q <= q_cmd_i.now;
              work_phase_q <= 1'b1;
            end
          end
          OpClear: begin
            for (int e = 0; e < INDICATOR_COUNT; e++) begin
              lvl_q[e] <= LvlOff;
              fon_q[e] <= 1'b0;
              dim_q[e] <= FullDim;
            end
            work_on_q  <= 1'b0;
            work_dim_q <= FullDim;
            work_rgb_q <= RgbWhite;
            work_fon_q <= 1'b0;
          end
          default: ;
        endcase
      end
      if (issue && tog) begin
        if (is_work) begin
          work_phase_q <= new_phase;
          work_stamp_q <= now_q;
        end else begin
          phase_q[ci] <= new_phase;
          stamp_q[ci] <= now_q;
        end
      end
    end
  end

  assign pix_o.valid = out_vld_q;
  assign pix_o.pixel = out_pix_q;
  assign pix_o.red   = out_r_q;
  assign pix_o.green = out_g_q;
  assign pix_o.blue  = out_b_q;
  assign pix_o.last  = out_last_q;

`ifndef NO_ASSERTIONS
  a_last_is_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_o.valid && pix_o.last |-> pix_o.pixel == WorkPixel)
    else $error("last beat not on worklight pixel");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> state_q == StIdle && !issue)
    else $error("command taken during refresh walk");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StWalk |-> cnt_q <= WorkPixel)
    else $error("walk counter beyond table");
`endif
endmodule

FILE: sv/indicator_blink_dim_controller.sv
// top level: indicator blink and dim controller
// Commands enter through a two-entry queue, so the command side keeps moving while results
// stall, until the queue is full. Set, worklight and clear commands are executed in the
// back end as they leave the queue. A refresh leaves the queue, then walks the table
// through its single read port, one entry per cycle while the sink is ready, and delivers
// INDICATOR_COUNT + 1 result beats (the last for the worklight) at one beat per cycle
// while the sink is ready, so a refresh occupies the back end until its worklight entry
// is taken, longer while the sink stalls; the first beat passes the walk state and
// counter, the phase check register and then the dimming output register. The flash
// interval register is written through cfg_we_i / cfg_wdata_i and resets to 500 ms.
module indicator_blink_dim_controller #(
  parameter int unsigned INDICATOR_COUNT = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [ibd_pkg::IntW-1:0] cfg_wdata_i,
  ibd_cmd_if.sink                  cmd_i,
  ibd_pix_if.source                pix_o
);
  import ibd_pkg::*;

  logic      push, pop, q_valid;
  ibd_cmd_t  push_cmd, q_cmd;
  ibd_qctl_t qctl;

  ibd_front #(.INDICATOR_COUNT(INDICATOR_COUNT)) u_front (
    .cmd_i   (cmd_i),
    .full_i  (qctl.full),
    .push_o  (push),
    .entry_o (push_cmd)
  );

  ibd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .pop_i   (pop),
    .ctl_o   (qctl),
    .valid_o (q_valid),
    .rdata_o (q_cmd)
  );

  ibd_back #(.INDICATOR_COUNT(INDICATOR_COUNT)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .q_pop_o     (pop),
    .pix_o       (pix_o)
  );
endmodule

FILE: sim/tb_indicator_blink_dim_controller.sv
// self-checking testbench for the indicator blink and dim controller
`timescale 1ns / 100ps

module tb_indicator_blink_dim_controller;
  import ibd_pkg::*;

  localparam int unsigned NUM_LAMPS   = 10;
  localparam int unsigned NUM_PHASES  = 6;
  localparam int unsigned RAND_PER_PH = 51;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned BURST_ITEMS = 24;
  localparam int unsigned SETTLE_CYC  = 16;
  localparam int unsigned CYCLE_LIMIT = 600000;

  typedef struct {
    ibd_op_e     op;
    logic [31:0] now_ms;
    logic [3:0]  index;
    logic [2:0]  level;
    logic        flash;
    logic [7:0]  brightness;
    logic        enable;
    logic [23:0] color_rgb;
    int unsigned gap;
    bit          drain;
  } cmd_item_t;

  typedef struct packed {
    logic [3:0] pixel;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pix_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [IntW-1:0] cfg_wdata_i;

  ibd_cmd_if cmd_bus ();
  ibd_pix_if pix_bus ();

  indicator_blink_dim_controller #(
    .INDICATOR_COUNT(NUM_LAMPS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_i      (cmd_bus),
    .pix_o      (pix_bus)
  );

  always #10 clk_i = ~clk_i;

  // shadow of the lamp table, worklight and flash interval
  logic [2:0]  lamp_level [NUM_LAMPS];
  logic        lamp_blink [NUM_LAMPS];
  logic [31:0] lamp_stamp [NUM_LAMPS];
  logic        lamp_phase [NUM_LAMPS];
  logic [7:0]  lamp_dim   [NUM_LAMPS];
  logic        wl_on;
  logic [7:0]  wl_dim;
  logic [23:0] wl_rgb;
  logic        wl_blink;
  logic [31:0] wl_stamp;
  logic        wl_phase;
  logic [15:0] blink_ms;

  cmd_item_t   cmd_backlog [$];
  pix_beat_t   color_due   [$];
  cmd_item_t   drv_cur;

  logic        cmd_fire;
  logic        pix_fire;
  bit          tx_quiet;
  bit          rx_quiet;
  int unsigned tx_idle;
  int unsigned rx_wait;
  int unsigned hold_req;
  int unsigned hold_done;
  int unsigned hold_left;
  int unsigned burst_left;
  int unsigned cycle_cnt;
  int unsigned mismatches;
  int unsigned cmds_taken;
  int unsigned refreshes;
  int unsigned beats_seen;

  function automatic logic [23:0] shade_of(logic [2:0] lvl);
    case (lvl)
      LvlGreen:  return RgbGreen;
      LvlOrange: return RgbOrange;
      LvlRed:    return RgbRed;
      LvlBlue:   return RgbBlue;
      default:   return RgbBlack;
    endcase
  endfunction

  // wrapping elapsed time against the interval
  function automatic bit blink_due(logic [31:0] now, logic [31:0] stamp);
    logic [31:0] gone;
    gone = now - stamp;
    return gone > {16'd0, blink_ms};
  endfunction

  function automatic pix_beat_t make_beat(logic [3:0] pix, logic [23:0] rgb, logic [7:0] dim,
                                          logic fin);
    pix_beat_t   b;
    int unsigned r;
    int unsigned g;
    int unsigned bl;
    r  = rgb[23:16];
    g  = rgb[15:8];
    bl = rgb[7:0];
    if (dim != FullDim) begin
      r  = (r * dim) / 255;
      g  = (g * dim) / 255;
      bl = (bl * dim) / 255;
    end
    b.pixel = pix;
    b.red   = 8'(r);
    b.green = 8'(g);
    b.blue  = 8'(bl);
    b.last  = fin;
    return b;
  endfunction

  task automatic load_lamp(int unsigned i, cmd_item_t c);
    lamp_level[i] = c.level;
    lamp_blink[i] = c.flash;
    lamp_dim[i]   = c.brightness;
    if (c.flash) begin
      lamp_stamp[i] = c.now_ms;
      lamp_phase[i] = 1'b1;
    end
  endtask

  task automatic clear_table(bit full);
    for (int i = 0; i < NUM_LAMPS; i++) begin
      lamp_level[i] = LvlOff;
      lamp_blink[i] = 1'b0;
      lamp_dim[i]   = FullDim;
      if (full) begin
        lamp_stamp[i] = '0;
        lamp_phase[i] = 1'b0;
      end
    end
    wl_on    = 1'b0;
    wl_dim   = FullDim;
    wl_rgb   = RgbWhite;
    wl_blink = 1'b0;
    if (full) begin
      wl_stamp = '0;
      wl_phase = 1'b0;
    end
  endtask

  // updates the shadow state and queues the colors a refresh emits
  task automatic predict_colors(cmd_item_t c);
    logic [23:0] rgb;
    case (c.op)
      OpSet: begin
        if (c.index < NUM_LAMPS) begin
          if (c.index == LinkA || c.index == LinkB) begin
            load_lamp(LinkA, c);
            load_lamp(LinkB, c);
          end else begin
            load_lamp(c.index, c);
          end
        end
      end
      OpWork: begin
        wl_on    = c.enable;
        wl_dim   = c.brightness;
        wl_blink = c.flash;
        if (c.color_rgb != RgbBlack) wl_rgb = c.color_rgb;
        if (c.flash) begin
          wl_stamp = c.now_ms;
          wl_phase = 1'b1;
        end
      end
      OpClear: clear_table(1'b0);
      default: begin
        refreshes++;
        for (int i = 0; i < NUM_LAMPS; i++) begin
          rgb = RgbBlack;
          if (lamp_level[i] <= LvlBlue) begin
            rgb = shade_of(lamp_level[i]);
            if (lamp_blink[i] && lamp_level[i] != LvlOff) begin
              if (blink_due(c.now_ms, lamp_stamp[i])) begin
                lamp_phase[i] = !lamp_phase[i];
                lamp_stamp[i] = c.now_ms;
              end
              if (!lamp_phase[i]) rgb = RgbBlack;
            end
          end
          color_due.push_back(make_beat(4'(i), rgb, lamp_dim[i], 1'b0));
        end
        rgb = RgbBlack;
        if (wl_on) begin
          rgb = wl_rgb;
          if (wl_blink) begin
            if (blink_due(c.now_ms, wl_stamp)) begin
              wl_phase = !wl_phase;
              wl_stamp = c.now_ms;
            end
            if (!wl_phase) rgb = RgbBlack;
          end
        end
        color_due.push_back(make_beat(4'(NUM_LAMPS), rgb, wl_on ? wl_dim : FullDim, 1'b1));
      end
    endcase
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  function automatic cmd_item_t mk_cmd(ibd_op_e op, logic [31:0] ts, logic [3:0] idx,
                                       logic [2:0] lvl, logic fl, logic [7:0] dim,
                                       logic en, logic [23:0] rgb);
    cmd_item_t it;
    it.op         = op;
    it.now_ms     = ts;
    it.index      = idx;
    it.level      = lvl;
    it.flash      = fl;
    it.brightness = dim;
    it.enable     = en;
    it.color_rgb  = rgb;
    it.gap        = 0;
    it.drain      = 1'b0;
    return it;
  endfunction

  function automatic logic [7:0] pick_dim();
    int unsigned p;
    p = $urandom_range(0, 9);
    if (p < 4) return FullDim;
    if (p == 4) return 8'd0;
    return 8'($urandom);
  endfunction

  // mostly table writes and refreshes, with out-of-table and black levels as noise
  function automatic cmd_item_t roll_cmd(logic [31:0] ts);
    cmd_item_t   it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    it = mk_cmd(OpRefresh, ts, 4'($urandom), 3'($urandom), 1'($urandom), 8'($urandom),
                1'($urandom), 24'($urandom));
    if (pick < 45) begin
      it.op = OpSet;
      it.index = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, NUM_LAMPS - 1))
                                              : 4'($urandom_range(NUM_LAMPS, 15));
      it.level = ($urandom_range(0, 99) < 80) ? 3'($urandom_range(0, 4))
                                              : 3'($urandom_range(5, 7));
      it.brightness = pick_dim();
    end else if (pick < 60) begin
      it.op = OpWork;
      it.enable = ($urandom_range(0, 99) < 80);
      if ($urandom_range(0, 4) == 0) it.color_rgb = RgbBlack;
      it.brightness = pick_dim();
    end else if (pick < 96) begin
      it.op = OpRefresh;
    end else begin
      it.op = OpClear;
    end
    return it;
  endfunction

  task automatic push_cmd(cmd_item_t it, bit drain);
    it.drain = drain;
    if (burst_left > 0) begin
      it.gap = 0;
      burst_left--;
    end else begin
      it.gap = tx_quiet ? 0 : $urandom_range(0, 19);
    end
    cmd_backlog.push_back(it);
  endtask

  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || cmd_bus.valid || color_due.size() != 0)
      @(posedge clk_i);
    // set and clear beats leave no result, give the back end time to finish
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin : scoreboard
    pix_beat_t want;
    cmd_fire <= cmd_bus.valid && cmd_bus.ready;
    pix_fire <= pix_bus.valid && pix_bus.ready;
    if (rst_ni && pix_bus.valid && pix_bus.ready) begin
      if (color_due.size() == 0) begin
        $error("color beat for pixel %0d with nothing expected", pix_bus.pixel);
        mismatches++;
      end else begin
        want = color_due.pop_front();
        check_field("pixel", want.pixel, pix_bus.pixel);
        check_field("red", want.red, pix_bus.red);
        check_field("green", want.green, pix_bus.green);
        check_field("blue", want.blue, pix_bus.blue);
        check_field("last", want.last, pix_bus.last);
        beats_seen++;
      end
    end
    if (rst_ni && cmd_bus.valid && cmd_bus.ready) begin
      predict_colors(drv_cur);
      cmds_taken++;
    end
  end

  always @(negedge clk_i) begin : cmd_driver
    logic offer;
    if (rst_ni) begin
      offer = cmd_bus.valid && !cmd_fire;
      if (!offer && cmd_backlog.size() != 0) begin
        if (tx_idle < cmd_backlog[0].gap) begin
          tx_idle++;
        end else if (!cmd_backlog[0].drain || color_due.size() == 0) begin
          drv_cur = cmd_backlog.pop_front();
          cmd_bus.func       <= drv_cur.op;
          cmd_bus.now_ms     <= drv_cur.now_ms;
          cmd_bus.index      <= drv_cur.index;
          cmd_bus.level      <= drv_cur.level;
          cmd_bus.flash      <= drv_cur.flash;
          cmd_bus.brightness <= drv_cur.brightness;
          cmd_bus.enable     <= drv_cur.enable;
          cmd_bus.color_rgb  <= drv_cur.color_rgb;
          offer   = 1'b1;
          tx_idle = 0;
        end
      end
      cmd_bus.valid <= offer;
    end
  end

  always @(negedge clk_i) begin : pix_receiver
    if (rst_ni) begin
      if (pix_fire) rx_wait = rx_quiet ? 0 : $urandom_range(0, 19);
      else if (rx_wait > 0) rx_wait--;
      if (hold_req != hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = hold_req;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      pix_bus.ready <= (rx_wait == 0) && (hold_left == 0);
    end
  end

  initial begin : stimulus
    logic [15:0] phase_ms [NUM_PHASES];
    logic [31:0] clock_ms;
    int unsigned span;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    cmd_bus.valid      = 1'b0;
    cmd_bus.func       = OpSet;
    cmd_bus.now_ms     = '0;
    cmd_bus.index      = '0;
    cmd_bus.level      = '0;
    cmd_bus.flash      = 1'b0;
    cmd_bus.brightness = '0;
    cmd_bus.enable     = 1'b0;
    cmd_bus.color_rgb  = '0;
    pix_bus.ready      = 1'b0;
    cmd_fire           = 1'b0;
    pix_fire           = 1'b0;
    tx_idle            = 0;
    rx_wait            = 0;
    hold_req           = 0;
    hold_done          = 0;
    hold_left          = 0;
    burst_left         = 0;
    cycle_cnt          = 0;
    mismatches         = 0;
    cmds_taken         = 0;
    refreshes          = 0;
    beats_seen         = 0;
    blink_ms           = IntervalReset;
    clear_table(1'b1);
    phase_ms = '{IntervalReset, 16'd0, 16'd1, 16'hFFFF, 16'($urandom_range(2, 65534)),
                 IntervalReset};
    clock_ms = 32'd2000;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        wait_idle();
        cfg_we_i    <= 1'b1;
        cfg_wdata_i <= phase_ms[p];
        @(negedge clk_i);
        cfg_we_i <= 1'b0;
        blink_ms = phase_ms[p];
      end
      tx_quiet = (p == 1) || (p == 2);
      rx_quiet = (p == 2) || (p == 4);

      if (p == 0) begin
        push_cmd(mk_cmd(OpRefresh, 32'd0, 4'd0, LvlOff, 1'b0, FullDim, 1'b0, RgbBlack), 0);
        push_cmd(mk_cmd(OpSet, 32'd10, 4'd0, LvlGreen, 1'b0, FullDim, 1'b0, RgbBlack), 0);
        push_cmd(mk_cmd(OpSet, 32'd20, 4'd1, LvlOrange, 1'b0, 8'd128, 1'b0, RgbBlack), 0);
        push_cmd(mk_cmd(OpSet, 32'd30, 4'd2, LvlRed, 1'b0, 8'd0, 1'b0, RgbBlack), 0);
        push_cmd(mk_cmd(OpSet, 32'd1000, 4'd3, LvlBlue, 1'b1, 8'd254, 1'b0, RgbBlack), 0);
        // linked pair through the low index
        push_cmd(mk_cmd(OpSet, 32'd1000, LinkA, LvlGreen, 1'b1, 8'd200, 1'b0, RgbBlack), 0);
        push_cmd(mk_cmd(OpSet, 32'd1000, 4'd6, 3'd5, 1'b1, FullDim, 1'b0, RgbBlack), 0);
        push_cmd(mk_cmd(OpSet, 32'd1000, 4'd7, 3'd7, 1'b0, 8'd77, 1'b0, RgbBlack), 0);
        push_cmd(mk_cmd(OpSet, 32'd1000, 4'd8, LvlOff, 1'b1, FullDim, 1'b0, RgbBlack), 0);
        push_cmd(mk_cmd(OpSet, 32'd1000, 4'd9, 3'd6, 1'b1, 8'd1, 1'b0, RgbBlack), 0);
        push_cmd(mk_cmd(OpSet, 32'd1000, 4'd10, LvlRed, 1'b1, FullDim, 1'b0, RgbBlack), 0);
        push_cmd(mk_cmd(OpWork, 32'd1100, 4'd0, LvlOff, 1'b0, FullDim, 1'b1, 24'h123456), 0);
        push_cmd(mk_cmd(OpRefresh, 32'd1200, 4'd0, LvlOff, 1'b0, FullDim, 1'b0, RgbBlack), 0);
        // zero color keeps the old one; sender waits for the refresh to drain
        push_cmd(mk_cmd(OpWork, 32'd1300, 4'd0, LvlOff, 1'b1, 8'd100, 1'b1, RgbBlack), 1);
        // exactly the interval since the worklight stamp: no toggle yet
        push_cmd(mk_cmd(OpRefresh, 32'd1800, 4'd0, LvlOff, 1'b0, FullDim, 1'b0, RgbBlack), 0);
        push_cmd(mk_cmd(OpRefresh, 32'd1801, 4'd0, LvlOff, 1'b0, FullDim, 1'b0, RgbBlack), 0);
        push_cmd(mk_cmd(OpWork, 32'd1900, 4'd0, LvlOff, 1'b1, FullDim, 1'b0, 24'hABCDEF), 0);
        push_cmd(mk_cmd(OpRefresh, 32'hFFFF_FFF0, 4'd0, LvlOff, 1'b0, FullDim, 1'b0,
                        RgbBlack), 0);
        push_cmd(mk_cmd(OpSet, 32'hFFFF_FF00, LinkB, LvlOrange, 1'b1, FullDim, 1'b0,
                        RgbBlack), 0);
        push_cmd(mk_cmd(OpWork, 32'hFFFF_FF00, 4'd0, LvlOff, 1'b1, 8'd0, 1'b1, RgbWhite), 0);
        // elapsed time wraps through zero
        push_cmd(mk_cmd(OpRefresh, 32'h0000_0100, 4'd0, LvlOff, 1'b0, FullDim, 1'b0,
                        RgbBlack), 0);
        push_cmd(mk_cmd(OpClear, 32'h0000_0180, 4'hF, 3'd7, 1'b1, 8'd3, 1'b1, 24'h777777), 0);
        push_cmd(mk_cmd(OpRefresh, 32'h0000_0200, 4'd0, LvlOff, 1'b0, FullDim, 1'b0,
                        RgbBlack), 0);
      end
      if (p == 1) begin
        // zero interval: no elapsed time holds, one millisecond toggles
        push_cmd(mk_cmd(OpSet, clock_ms, 4'd0, LvlRed, 1'b1, FullDim, 1'b0, RgbBlack), 0);
        push_cmd(mk_cmd(OpRefresh, clock_ms, 4'd0, LvlOff, 1'b0, FullDim, 1'b0, RgbBlack), 0);
        push_cmd(mk_cmd(OpRefresh, clock_ms + 1, 4'd0, LvlOff, 1'b0, FullDim, 1'b0,
                        RgbBlack), 0);
      end
      if (p == 2) clock_ms = 32'hFFFF_FE00;
      if (p == 3) begin
        // results stall for a long stretch while commands keep coming
        hold_req++;
        burst_left = BURST_ITEMS;
      end

      span = 2 * phase_ms[p] + 3;
      for (int n = 0; n < RAND_PER_PH; n++) begin
        if ($urandom_range(0, 99) < 3) clock_ms = $urandom;
        else clock_ms = clock_ms + $urandom_range(0, span);
        push_cmd(roll_cmd(clock_ms), $urandom_range(0, 29) == 0);
      end
    end

    wait_idle();
    $display("run covered %0d commands, %0d refreshes and %0d color beats", cmds_taken,
             refreshes, beats_seen);
    $display("over %0d flash interval settings, with stalls on both channels", NUM_PHASES);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
